// ----- rtl/bic_pkg.sv -----
// Shared types and constants for the binarized im2col scatter block.
package bic_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_STEP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_AMOUNT      = 3'd6;

  // Only this geometry produces results
  localparam logic [2:0] KERNEL_SUPPORTED = 3'd3;
  localparam logic [2:0] STRIDE_SUPPORTED = 3'd1;
  localparam logic [1:0] PAD_SUPPORTED    = 2'd1;

  localparam logic [20:0] STRIDE_LIMIT = 21'd1048576;

  // Float32 +Inf; anything above with sign clear is NaN
  localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;

  localparam int IDX_W = 34;
  localparam int TAPS  = 9;

  // Job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Saturated, decoded configuration
  typedef struct packed {
    logic [10:0] height;
    logic [10:0] width;
    logic [10:0] chans;
    logic [20:0] stride;
    logic        ok;
  } geom_t;

  // One classified pixel: index of tap (0,0) and the set of live taps
  typedef struct packed {
    logic [IDX_W-1:0] base;
    logic [TAPS-1:0]  taps;
  } job_t;

endpackage

// ----- rtl/binary_im2col_scatter_top.sv -----
// Top level of the binarized im2col scatter: config registers, front, queue, back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------------
//  pixel in | in        | push / full               | channel, pixel_row, pixel_col, pixel_bits
//  index out| out       | pop / empty               | bit_index, last
//  config   | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One bit index per cycle while pop is held and jobs are queued; a pixel with n
// live taps (1 to 9) gives n bit indices, so a fully interior pixel gives 9. The output
// register and the back-end tap walk set this rate. A pixel's first index passes stage A,
// stage B, queue, job reg and output reg. Pixels that feed nothing are dropped at the input.
// Reset is synchronous; it empties the pipe and queue and restores register defaults.
// full rises when the 4-entry job queue plus jobs in flight could not take another pixel.
module binary_im2col_scatter_top #(
  parameter int MAX_DIM      = 1024,
  parameter int MAX_CHANNELS = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [9:0]                       channel,
  input  logic [9:0]                       pixel_row,
  input  logic [9:0]                       pixel_col,
  input  logic [31:0]                      pixel_bits,
  output logic                             empty,
  input  logic                             pop,
  output logic [bic_pkg::IDX_W-1:0]        bit_index,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bic_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bic_pkg::*;

  logic [10:0] image_height;
  logic [10:0] image_width;
  logic [10:0] channel_count;
  logic [20:0] row_stride_bits;
  logic [2:0]  kernel_size;
  logic [2:0]  stride_step;
  logic [1:0]  pad_amount;

  geom_t              geom;
  logic               q_push;
  job_t               q_wdata;
  job_t               q_rdata;
  logic               q_pop;
  logic               q_empty;
  logic [QCNT_W-1:0]  q_count;

  assign cfg_ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height    <= 11'd32;
      image_width     <= 11'd32;
      channel_count   <= 11'd1;
      row_stride_bits <= 21'd1024;
      kernel_size     <= 3'd3;
      stride_step     <= 3'd1;
      pad_amount      <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_HEIGHT:    image_height    <= cfg_data[10:0];
        CFG_IMAGE_WIDTH:     image_width     <= cfg_data[10:0];
        CFG_CHANNEL_COUNT:   channel_count   <= cfg_data[10:0];
        CFG_ROW_STRIDE_BITS: row_stride_bits <= cfg_data[20:0];
        CFG_KERNEL_SIZE:     kernel_size     <= cfg_data[2:0];
        CFG_STRIDE_STEP:     stride_step     <= cfg_data[2:0];
        CFG_PAD_AMOUNT:      pad_amount      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Saturated geometry
  always_comb begin
    geom.height = ({2'b0, image_height} > 13'(MAX_DIM)) ? 11'(MAX_DIM) : image_height;
    geom.width  = ({2'b0, image_width} > 13'(MAX_DIM)) ? 11'(MAX_DIM) : image_width;
    geom.chans  = ({2'b0, channel_count} > 13'(MAX_CHANNELS)) ?
                  11'(MAX_CHANNELS) : channel_count;
    geom.stride = (row_stride_bits > STRIDE_LIMIT) ? STRIDE_LIMIT : row_stride_bits;
    geom.ok     = (kernel_size == KERNEL_SUPPORTED) && (stride_step == STRIDE_SUPPORTED) &&
                  (pad_amount == PAD_SUPPORTED);
  end

  bic_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .channel    (channel),
    .pixel_row  (pixel_row),
    .pixel_col  (pixel_col),
    .pixel_bits (pixel_bits),
    .geom       (geom),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  bic_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  bic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_data    (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .bit_index (bit_index),
    .last      (last)
  );

endmodule

// ----- rtl/bic_front.sv -----
// Front end: accepts pixels, drops non-contributing ones, builds jobs.
module bic_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [9:0]         channel,
  input  logic [9:0]         pixel_row,
  input  logic [9:0]         pixel_col,
  input  logic [31:0]        pixel_bits,
  input  bic_pkg::geom_t     geom,
  input  logic [bic_pkg::QCNT_W-1:0] q_count,
  output logic               q_push,
  output bic_pkg::job_t      q_data
);
  import bic_pkg::*;

  logic              accept;
  logic              keep;
  logic              positive;
  logic [2:0]        row_ok;
  logic [2:0]        col_ok;
  logic [TAPS-1:0]   mask;
  logic [13:0]       ch9;
  logic [34:0]       prod_s_full;
  logic [10:0]       r1;
  logic [10:0]       c1;
  logic [21:0]       prod_w_full;
  logic [QCNT_W:0]   in_flight;

  // Stage A: products
  logic              a_v;
  logic [IDX_W-1:0]  a_prod_s;
  logic [21:0]       a_prod_w;
  logic [10:0]       a_c1;
  logic [TAPS-1:0]   a_mask;

  // Stage B: job ready for the queue
  logic              b_v;
  job_t              b_job;

  // Credit check: queue entries plus jobs still in the pipe
  assign in_flight = {1'b0, q_count} + (QCNT_W+1)'(a_v) + (QCNT_W+1)'(b_v);
  assign full      = in_flight >= (QCNT_W+1)'(QDEPTH);
  assign accept    = push && !full;

  // Classification
  assign positive = (pixel_bits != 32'd0) && (pixel_bits <= POS_INF_BITS);
  assign keep = geom.ok && positive &&
                ({1'b0, channel} < geom.chans) &&
                ({1'b0, pixel_row} < geom.height) &&
                ({1'b0, pixel_col} < geom.width);

  assign r1 = {1'b0, pixel_row} + 11'd1;
  assign c1 = {1'b0, pixel_col} + 11'd1;

  // Kernel row kr lands on output row r+1-kr
  assign row_ok[0] = r1 < geom.height;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = pixel_row != 10'd0;
  assign col_ok[0] = c1 < geom.width;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = pixel_col != 10'd0;

  always_comb begin
    for (int kr = 0; kr < 3; kr++) begin
      for (int kc = 0; kc < 3; kc++) begin
        mask[kr*3 + kc] = row_ok[kr] && col_ok[kc];
      end
    end
  end

  // channel*9 by shift and add
  assign ch9         = {1'b0, channel, 3'b000} + {4'b0, channel};
  assign prod_s_full = ch9 * geom.stride;
  assign prod_w_full = r1 * geom.width;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      a_v <= accept && keep;
      b_v <= a_v;
    end
  end

  // Payload pipeline
  always_ff @(posedge clk) begin
    a_prod_s   <= prod_s_full[IDX_W-1:0];
    a_prod_w   <= prod_w_full;
    a_c1       <= c1;
    a_mask     <= mask;
    b_job.base <= a_prod_s + IDX_W'(a_prod_w) + IDX_W'(a_c1);
    b_job.taps <= a_mask;
  end

  assign q_push = b_v;
  assign q_data = b_job;

endmodule

// ----- rtl/bic_fifo.sv -----
// Short job queue between front and back ends.
module bic_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  bic_pkg::job_t               wdata,
  input  logic                        pop,
  output bic_pkg::job_t               rdata,
  output logic                        empty,
  output logic [bic_pkg::QCNT_W-1:0]  count
);
  import bic_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != QCNT_W'(QDEPTH))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("job queue underflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("job queue count out of range");

endmodule

// ----- rtl/bic_back.sv -----
// Back end: walks the live taps of a job, one bit index per transfer.
module bic_back (
  input  logic                   clk,
  input  logic                   rst,
  input  bic_pkg::geom_t         geom,
  input  bic_pkg::job_t          q_data,
  input  logic                   q_empty,
  output logic                   q_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [bic_pkg::IDX_W-1:0] bit_index,
  output logic                   last
);
  import bic_pkg::*;

  logic              job_v;
  job_t              job;
  logic              o_v;
  logic [IDX_W-1:0]  o_idx;
  logic              o_last;

  logic              adv;
  logic              emit;
  logic              need_load;
  logic [TAPS-1:0]   pick;
  logic [TAPS-1:0]   rest;
  logic [22:0]       s3;
  logic [IDX_W-1:0]  step_r;
  logic [IDX_W-1:0]  step_c;
  logic [IDX_W-1:0]  row_term;
  logic [IDX_W-1:0]  col_term;
  logic [IDX_W-1:0]  idx;

  // Lowest live tap goes out first (ascending kr, then kc)
  assign pick = job.taps & (~job.taps + TAPS'(1));
  assign rest = job.taps & ~pick;

  // Per-tap offsets: +1 kernel row is 3S-W, +1 kernel col is S-1
  assign s3     = {1'b0, geom.stride, 1'b0} + {2'b0, geom.stride};
  assign step_r = IDX_W'(s3) - IDX_W'(geom.width);
  assign step_c = IDX_W'(geom.stride) - IDX_W'(1);

  always_comb begin
    row_term = '0;
    col_term = '0;
    if (pick[5:3] != 3'b000) row_term = step_r;
    if (pick[8:6] != 3'b000) row_term = {step_r[IDX_W-2:0], 1'b0};
    if (pick[1] || pick[4] || pick[7]) col_term = step_c;
    if (pick[2] || pick[5] || pick[8]) col_term = {step_c[IDX_W-2:0], 1'b0};
  end

  assign idx = job.base + row_term + col_term;

  // Handshake with output register and job queue
  assign adv       = !o_v || pop;
  assign emit      = adv && job_v;
  assign need_load = !job_v || (emit && rest == '0);
  assign q_pop     = need_load && !q_empty;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      job_v <= 1'b0;
      o_v   <= 1'b0;
    end else begin
      if (need_load) job_v <= !q_empty;
      if (emit) o_v <= 1'b1;
      else if (pop) o_v <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (need_load) job <= q_data;
    else if (emit) job.taps <= rest;
    if (emit) begin
      o_idx  <= idx;
      o_last <= rest == '0;
    end
  end

  assign empty     = !o_v;
  assign bit_index = o_idx;
  assign last      = o_last;

  a_job_has_taps: assert property (@(posedge clk) disable iff (rst)
    job_v |-> job.taps != '0)
    else $error("active job with no live taps");

  a_emit_fills_out: assert property (@(posedge clk) disable iff (rst)
    emit |=> o_v)
    else $error("emitted index not held in output register");

endmodule
